// ===== rtl/ght_pkg.sv =====
// Shared types, constants and codes for the generational handle table.
package ght_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int HALF_W    = 16;
    localparam int HANDLE_W  = 32;
    localparam int REF_W     = 16;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 7;
    localparam int GRP_W     = 3;
    localparam int GRP       = 1 << GRP_W;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 3'd0,
        OP_INSERT  = 3'd1,
        OP_LOOKUP  = 3'd2,
        OP_RELEASE = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_ENUM    = 3'd5
    } ght_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_BAD_HANDLE = 3'd2,
        ST_BUSY       = 3'd3,
        ST_MISMATCH   = 3'd4
    } ght_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_ENUM_RD,
        S_ENUM_OUT
    } ght_state_t;

    typedef struct packed {
        logic [OP_W-1:0]     opcode;
        logic [REF_W-1:0]    object_ref;
        logic [HANDLE_W-1:0] handle_in;
        logic                check_generation;
    } ght_req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic [REF_W-1:0]    ref_out;
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  live_count;
        logic                is_last;
    } ght_rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic enum_init;
        logic enum_read;
        logic enum_step;
    } ght_cmd_t;

    typedef struct packed {
        logic is_enum;
        logic any_used;
        logic at_last;
    } ght_sts_t;

endpackage

// ===== rtl/ght_scan.sv =====
// Two-level search for the lowest free slot and the highest occupied slot.
module ght_scan #(
    parameter int SLOTS = ght_pkg::SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [SLOTS-1:0]         valid,
    output logic                     free_any,
    output logic [$clog2(SLOTS)-1:0] free_idx,
    output logic                     used_any,
    output logic [$clog2(SLOTS)-1:0] last_idx
);
    import ght_pkg::*;

    localparam int IDX_W    = $clog2(SLOTS);
    localparam int GROUPS   = (SLOTS + GRP - 1) / GRP;
    localparam int GROUPS_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int PAD      = GROUPS * GRP;
    localparam int FULL_W   = GROUPS_W + GRP_W;
    localparam logic [PAD-1:0] IN_MASK = PAD'({SLOTS{1'b1}});

    logic [PAD-1:0]            used_pad;
    logic [PAD-1:0]            free_pad;
    logic [GROUPS-1:0]         g_free_any_next, g_free_any_reg;
    logic [GROUPS-1:0]         g_used_any_next, g_used_any_reg;
    logic [GRP_W-1:0]          g_free_low_next [GROUPS];
    logic [GRP_W-1:0]          g_free_low_reg  [GROUPS];
    logic [GRP_W-1:0]          g_used_high_next[GROUPS];
    logic [GRP_W-1:0]          g_used_high_reg [GROUPS];
    logic [FULL_W-1:0]         free_full;
    logic [FULL_W-1:0]         last_full;

    assign used_pad = PAD'(valid);
    assign free_pad = ~used_pad & IN_MASK;

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            g_free_any_next[g]  = |free_pad[g*GRP +: GRP];
            g_used_any_next[g]  = |used_pad[g*GRP +: GRP];
            g_free_low_next[g]  = '0;
            g_used_high_next[g] = '0;
            for (int b = GRP - 1; b >= 0; b--)
            begin
                if (free_pad[g*GRP + b])
                begin
                    g_free_low_next[g] = GRP_W'(b);
                end
            end
            for (int b = 0; b < GRP; b++)
            begin
                if (used_pad[g*GRP + b])
                begin
                    g_used_high_next[g] = GRP_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_free_any_reg <= '0;
            g_used_any_reg <= '0;
        end
        else
        begin
            g_free_any_reg <= g_free_any_next;
            g_used_any_reg <= g_used_any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            g_free_low_reg[g]  <= g_free_low_next[g];
            g_used_high_reg[g] <= g_used_high_next[g];
        end
    end

    always_comb
    begin
        free_full = '0;
        last_full = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (g_free_any_reg[g])
            begin
                free_full = {GROUPS_W'(g), g_free_low_reg[g]};
            end
        end
        for (int g = 0; g < GROUPS; g++)
        begin
            if (g_used_any_reg[g])
            begin
                last_full = {GROUPS_W'(g), g_used_high_reg[g]};
            end
        end
    end

    assign free_any = |g_free_any_reg;
    assign used_any = |g_used_any_reg;
    assign free_idx = free_full[IDX_W-1:0];
    assign last_idx = last_full[IDX_W-1:0];

endmodule

// ===== rtl/ght_ctrl.sv =====
// Controller state machine sequencing single-slot operations and the enumerate walk.
module ght_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ght_pkg::ght_sts_t sts,
    output logic              busy,
    output ght_pkg::ght_cmd_t cmd
);
    import ght_pkg::*;

    ght_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.is_enum && sts.any_used)
                begin
                    cmd.enum_init = 1'b1;
                    state_next    = S_ENUM_RD;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ENUM_RD:
            begin
                cmd.enum_read = 1'b1;
                state_next    = S_ENUM_OUT;
            end
            S_ENUM_OUT:
            begin
                cmd.enum_step = 1'b1;
                state_next    = sts.at_last ? S_IDLE : S_ENUM_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ght_dp.sv =====
// Datapath: slot memories, valid bits, counters and the result register.
module ght_dp #(
    parameter int SLOTS = ght_pkg::SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ght_pkg::ght_req_t req,
    input  ght_pkg::ght_cmd_t cmd,
    output ght_pkg::ght_sts_t sts,
    output logic              result_valid,
    output ght_pkg::ght_rsp_t result
);
    import ght_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    logic [HANDLE_W-1:0] handle_mem [SLOTS];
    logic [REF_W-1:0]    ref_mem    [SLOTS];

    ght_req_t            req_reg;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [HALF_W-1:0]   gen_reg, gen_next;
    logic [IDX_W-1:0]    ptr_reg;
    logic [HANDLE_W-1:0] rd_handle_reg;
    logic [REF_W-1:0]    rd_ref_reg;
    ght_rsp_t            rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [HANDLE_W-1:0] wr_handle;
    logic [REF_W-1:0]    wr_ref;

    logic                free_any;
    logic [IDX_W-1:0]    free_idx;
    logic                used_any;
    logic [IDX_W-1:0]    last_idx;

    logic [HALF_W-1:0]   idx16;
    logic [IDX_W-1:0]    slot;
    logic                in_range;
    logic                slot_v;
    logic                hzero;

    ght_scan #(.SLOTS(SLOTS)) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (valid_reg),
        .free_any (free_any),
        .free_idx (free_idx),
        .used_any (used_any),
        .last_idx (last_idx)
    );

    assign rd_en   = cmd.load | cmd.enum_read;
    assign rd_addr = cmd.load ? req.handle_in[IDX_W-1:0] : ptr_reg;

    assign idx16    = req_reg.handle_in[HALF_W-1:0];
    assign slot     = idx16[IDX_W-1:0];
    assign in_range = idx16 < HALF_W'(SLOTS);
    assign slot_v   = in_range && valid_reg[slot];
    assign hzero    = req_reg.handle_in == '0;

    assign sts.is_enum  = req_reg.opcode == OP_ENUM;
    assign sts.any_used = used_any;
    assign sts.at_last  = ptr_reg == last_idx;

    always_comb
    begin
        valid_next     = valid_reg;
        count_next     = count_reg;
        gen_next       = gen_reg;
        wr_en          = 1'b0;
        wr_addr        = slot;
        wr_handle      = req_reg.handle_in;
        wr_ref         = req_reg.object_ref;
        rsp_next       = '0;
        rsp_valid_next = 1'b0;

        if (cmd.exec)
        begin
            rsp_valid_next   = 1'b1;
            rsp_next.is_last = 1'b1;
            rsp_next.status  = ST_OK;
            case (req_reg.opcode)
                OP_ALLOC:
                begin
                    if (free_any)
                    begin
                        wr_en                = 1'b1;
                        wr_addr              = free_idx;
                        wr_handle            = {gen_reg, HALF_W'(free_idx)};
                        valid_next[free_idx] = 1'b1;
                        count_next           = count_reg + 1'b1;
                        gen_next             = gen_reg + 1'b1;
                        rsp_next.handle_out  = {gen_reg, HALF_W'(free_idx)};
                    end
                    else
                    begin
                        rsp_next.status = ST_FULL;
                    end
                end
                OP_INSERT:
                begin
                    if (hzero || !in_range)
                    begin
                        rsp_next.status = ST_BAD_HANDLE;
                    end
                    else if (slot_v)
                    begin
                        rsp_next.status = ST_BUSY;
                    end
                    else
                    begin
                        wr_en            = 1'b1;
                        valid_next[slot] = 1'b1;
                        count_next       = count_reg + 1'b1;
                    end
                end
                OP_LOOKUP:
                begin
                    if (hzero || !in_range)
                    begin
                        rsp_next.status = ST_BAD_HANDLE;
                    end
                    else if (slot_v && (!req_reg.check_generation ||
                                        rd_handle_reg == req_reg.handle_in))
                    begin
                        rsp_next.handle_out = rd_handle_reg;
                        rsp_next.ref_out    = rd_ref_reg;
                        rsp_next.found      = 1'b1;
                    end
                end
                OP_RELEASE:
                begin
                    if (!in_range)
                    begin
                        rsp_next.status = ST_BAD_HANDLE;
                    end
                    else if (!slot_v || rd_ref_reg != req_reg.object_ref)
                    begin
                        rsp_next.status = ST_MISMATCH;
                    end
                    else
                    begin
                        valid_next[slot] = 1'b0;
                        count_next       = count_reg - 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    valid_next = '0;
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
            rsp_next.live_count = count_next;
        end
        else if (cmd.enum_step && valid_reg[ptr_reg])
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.handle_out = rd_handle_reg;
            rsp_next.ref_out    = rd_ref_reg;
            rsp_next.found      = 1'b1;
            rsp_next.status     = ST_OK;
            rsp_next.live_count = count_reg;
            rsp_next.is_last    = ptr_reg == last_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            handle_mem[wr_addr] <= wr_handle;
            ref_mem[wr_addr]    <= wr_ref;
        end
        if (rd_en)
        begin
            rd_handle_reg <= handle_mem[rd_addr];
            rd_ref_reg    <= ref_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            gen_reg       <= HALF_W'(1);
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            gen_reg       <= gen_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cmd.enum_init)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.enum_step)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
        end
    end

    assign result_valid = rsp_valid_reg;
    assign result       = rsp_reg;

endmodule

// ===== rtl/generational_handle_table.sv =====
// Top level of the generational handle table.
// A taken request is registered, executed in S_EXEC, and its result word registered.
// A new request is taken only while idle (busy low); enumerate holds busy while
// it walks up to the highest occupied slot, one registered slot-memory read per slot.
// Reset: table empty, generation 1, no clearing pass; slot memories are not reset.
// Result words show for one cycle under result_valid; the receiver cannot stall.
module generational_handle_table #(
    parameter int SLOTS = ght_pkg::SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ght_pkg::ght_req_t request,
    output logic              busy,
    output logic              result_valid,
    output ght_pkg::ght_rsp_t result
);
    import ght_pkg::*;

    ght_cmd_t cmd;
    ght_sts_t sts;

    ght_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    ght_dp #(.SLOTS(SLOTS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (request),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
